// ===== sv/ts2cd_pkg.sv =====
// ts2cd_pkg: shared types, constants and helpers for the timestamp to calendar converter
// no dependencies; imported by every other file of the block

package ts2cd_pkg;

	// pipeline depth, from input register to output register
	localparam int unsigned STAGES = 8;

	// configuration port
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned OFFSET_W   = 17;

	typedef enum logic [0:0] {
		REG_BIG_ENDIAN = 1'b0,
		REG_UTC_OFFSET = 1'b1
	} cfg_reg_t;

	// item payloads
	typedef struct packed {
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
	} stamp_t;

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [11:0] year_full;
		logic [4:0]  hour_of_day;
		logic [5:0]  minute_of_hour;
		logic [5:0]  second_of_minute;
	} cal_t;

	// per-stage load enables and valid bits
	typedef struct packed {
		logic [STAGES:1] en;
		logic [STAGES:1] vld;
	} pipe_ctl_t;

	// internal widths
	localparam int unsigned TOTAL_W = 33;  // biased seconds, always non-negative
	localparam int unsigned DAYS_W  = 16;  // biased day count
	localparam int unsigned SECS_W  = 17;  // seconds of the day
	localparam int unsigned Z_W     = 18;  // days since 1600-03-01

	// (3804 + 21053) days in seconds: epoch of 1980-06-01 plus a bias that keeps
	// the sum positive over the whole input range
	localparam logic [TOTAL_W-1:0] EPOCH_BIAS = 33'd2147644800;

	// biased day count to days since 1600-03-01: 135080 - 21053
	localparam logic [Z_W-1:0] Z_BIAS   = 18'd114027;
	localparam logic [Z_W-1:0] ERA_DAYS = 18'd146097;

	// seconds per day is 128 * 675; quotient by 675 via reciprocal, exact below 2^26
	localparam logic [26:0] DAY_RECIP = 27'd101806633;
	localparam int unsigned DAY_SHIFT = 36;
	localparam logic [9:0]  DAY_ODD   = 10'd675;

	// hour and minute split, exact over the seconds of one day
	localparam logic [17:0] HOUR_RECIP = 18'd149131;
	localparam int unsigned HOUR_SHIFT = 29;
	localparam logic [12:0] MIN_RECIP  = 13'd4370;
	localparam int unsigned MIN_SHIFT  = 18;

	// leap day corrections inside one 400 year era
	localparam logic [18:0] QUAD_RECIP = 19'd367720;  // by 1460
	localparam int unsigned QUAD_SHIFT = 29;
	localparam logic [17:0] YEAR_RECIP = 18'd183860;  // by 365
	localparam int unsigned YEAR_SHIFT = 26;
	localparam logic [Z_W-1:0] CENT_DAYS = 18'd36524;
	localparam logic [Z_W-1:0] ERA_LAST  = 18'd146096;

	localparam logic [11:0] YEAR_BASE = 12'd1600;
	localparam logic [11:0] ERA_YEARS = 12'd400;

	// first day of each month within a year that starts in March
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/ts2cd_if.sv =====
// ts2cd_if: valid/ready channels for timestamp items and calendar items
// depends on ts2cd_pkg for the payload types

interface ts2cd_stamp_if import ts2cd_pkg::*; ();
	logic   valid;
	logic   ready;
	stamp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ts2cd_cal_if import ts2cd_pkg::*; ();
	logic valid;
	logic ready;
	cal_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ts2cd_pipe_ctrl.sv =====
// ts2cd_pipe_ctrl: valid bits and load enables of the pipeline stages
// depends on ts2cd_pkg; a stage loads when it is empty or the next one loads

module ts2cd_pipe_ctrl import ts2cd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;

	// enables ripple back from the output side
	always_comb begin
		en[STAGES] = !vld_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

// ===== sv/ts2cd_day_split.sv =====
// ts2cd_day_split: stages 1 to 3, byte assembly, epoch add and split into days and seconds
// depends on ts2cd_pkg; stage enables come from ts2cd_pipe_ctrl

module ts2cd_day_split import ts2cd_pkg::*; (
	input  logic                       clk,
	input  pipe_ctl_t                  ctl,
	input  stamp_t                     stamp,
	input  logic                       big_endian,
	input  logic signed [OFFSET_W-1:0] utc_offset,
	output logic [Z_W-1:0]             z_s3,
	output logic [SECS_W-1:0]          secs_s3
);

	logic [31:0]          word;
	logic [TOTAL_W:0]     total;
	logic [TOTAL_W-1:0]   t_s1;
	logic [52:0]          day_prod;
	logic [DAYS_W-1:0]    q_s2;
	logic [25:0]          hi_s2;
	logic [6:0]           lo_s2;
	logic [25:0]          q_odd;
	logic [25:0]          rem_hi;

	// stage 1: join bytes and add the biased epoch minus the zone offset
	always_comb begin
		if (big_endian) begin
			word = {stamp.byte_0, stamp.byte_1, stamp.byte_2, stamp.byte_3};
		end else begin
			word = {stamp.byte_3, stamp.byte_2, stamp.byte_1, stamp.byte_0};
		end
		total = {1'b0, EPOCH_BIAS} + {{2{word[31]}}, word}
			- {{(TOTAL_W + 1 - OFFSET_W){utc_offset[OFFSET_W-1]}}, utc_offset};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			t_s1 <= total[TOTAL_W-1:0];
		end
	end

	// stage 2: drop the factor 128, then divide by 675 with a reciprocal
	assign day_prod = 53'(t_s1[TOTAL_W-1:7]) * 53'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			q_s2  <= day_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
			hi_s2 <= t_s1[TOTAL_W-1:7];
			lo_s2 <= t_s1[6:0];
		end
	end

	// stage 3: seconds of the day and day count from 1600-03-01
	always_comb begin
		q_odd  = 26'(q_s2) * 26'(DAY_ODD);
		rem_hi = hi_s2 - q_odd;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			secs_s3 <= {rem_hi[9:0], lo_s2};
			z_s3    <= Z_W'(q_s2) + Z_BIAS;
		end
	end

endmodule

// ===== sv/ts2cd_clock.sv =====
// ts2cd_clock: stages 4 to 8, seconds of the day into hour, minute and second
// depends on ts2cd_pkg; stage enables come from ts2cd_pipe_ctrl

module ts2cd_clock import ts2cd_pkg::*; (
	input  logic              clk,
	input  pipe_ctl_t         ctl,
	input  logic [SECS_W-1:0] secs_s3,
	output logic [4:0]        hour_s8,
	output logic [5:0]        min_s8,
	output logic [5:0]        sec_s8
);

	logic [34:0]       hour_prod;
	logic [4:0]        hour_s4, hour_s5, hour_s6, hour_s7;
	logic [SECS_W-1:0] secs_s4;
	logic [SECS_W-1:0] rem_full;
	logic [11:0]       rem_s5, rem_s6;
	logic [24:0]       min_prod;
	logic [5:0]        min_s6, min_s7;
	logic [11:0]       sec_full;
	logic [5:0]        sec_s7;

	// stage 4: hour by reciprocal
	assign hour_prod = 35'(secs_s3) * 35'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			hour_s4 <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
			secs_s4 <= secs_s3;
		end
	end

	// stage 5: seconds within the hour
	assign rem_full = secs_s4 - SECS_W'(hour_s4) * SECS_W'(3600);

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			rem_s5  <= rem_full[11:0];
			hour_s5 <= hour_s4;
		end
	end

	// stage 6: minute by reciprocal
	assign min_prod = 25'(rem_s5) * 25'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			min_s6  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
			rem_s6  <= rem_s5;
			hour_s6 <= hour_s5;
		end
	end

	// stage 7: second within the minute
	assign sec_full = rem_s6 - 12'(min_s6) * 12'd60;

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			sec_s7  <= sec_full[5:0];
			min_s7  <= min_s6;
			hour_s7 <= hour_s6;
		end
	end

	// stage 8: output register
	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			hour_s8 <= hour_s7;
			min_s8  <= min_s7;
			sec_s8  <= sec_s7;
		end
	end

endmodule

// ===== sv/ts2cd_civil.sv =====
// ts2cd_civil: stages 4 to 8, day count into Gregorian year, month and day
// depends on ts2cd_pkg; stage enables come from ts2cd_pipe_ctrl

module ts2cd_civil import ts2cd_pkg::*; (
	input  logic           clk,
	input  pipe_ctl_t      ctl,
	input  logic [Z_W-1:0] z_s3,
	output logic [4:0]     day_s8,
	output logic [3:0]     month_s8,
	output logic [11:0]    year_s8
);

	logic            era_hi;
	logic [Z_W-1:0]  doe_s4, doe_s5, doe_s6;
	logic            era_s4, era_s5, era_s6, era_s7;
	logic [36:0]     quad_prod;
	logic [2:0]      cent_cnt;
	logic [6:0]      quad_s5;
	logic [2:0]      cent_s5;
	logic            last_s5;
	logic [Z_W-1:0]  n_days;
	logic [35:0]     year_prod;
	logic [8:0]      yoe_s6, yoe_s7;
	logic [1:0]      yoe_cent;
	logic [Z_W-1:0]  year_days;
	logic [Z_W-1:0]  doy_full;
	logic [8:0]      doy_s7;
	logic [3:0]      mp;
	logic [3:0]      month;
	logic [8:0]      day_full;
	logic [11:0]     year;

	// stage 4: pick the 400 year era, 1600 or 2000
	assign era_hi = z_s3 >= ERA_DAYS;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			doe_s4 <= era_hi ? z_s3 - ERA_DAYS : z_s3;
			era_s4 <= era_hi;
		end
	end

	// stage 5: leap day counts inside the era
	always_comb begin
		quad_prod = 37'(doe_s4) * 37'(QUAD_RECIP);
		cent_cnt  = 3'(doe_s4 >= CENT_DAYS) + 3'(doe_s4 >= 18'(2 * CENT_DAYS))
			+ 3'(doe_s4 >= 18'(3 * CENT_DAYS)) + 3'(doe_s4 >= ERA_LAST);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			quad_s5 <= quad_prod[QUAD_SHIFT+6:QUAD_SHIFT];
			cent_s5 <= cent_cnt;
			last_s5 <= doe_s4 >= ERA_LAST;
			doe_s5  <= doe_s4;
			era_s5  <= era_s4;
		end
	end

	// stage 6: year of era by reciprocal of 365
	always_comb begin
		n_days    = doe_s5 - Z_W'(quad_s5) + Z_W'(cent_s5) - Z_W'(last_s5);
		year_prod = 36'(n_days) * 36'(YEAR_RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			yoe_s6 <= year_prod[YEAR_SHIFT+8:YEAR_SHIFT];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
	end

	// stage 7: day of the March-based year
	always_comb begin
		yoe_cent  = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
		year_days = Z_W'(yoe_s6) * Z_W'(365) + Z_W'(yoe_s6[8:2]) - Z_W'(yoe_cent);
		doy_full  = doe_s6 - year_days;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			doy_s7 <= doy_full[8:0];
			yoe_s7 <= yoe_s6;
			era_s7 <= era_s6;
		end
	end

	// stage 8: month by boundary compares, then day and full year
	always_comb begin
		mp = '0;
		for (int k = 1; k < 12; k++) begin
			mp = mp + 4'(doy_s7 >= month_start(4'(k)));
		end
		month    = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		day_full = doy_s7 - month_start(mp) + 9'd1;
		year     = YEAR_BASE + (era_s7 ? ERA_YEARS : 12'd0) + 12'(yoe_s7)
			+ 12'(month <= 4'd2);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			day_s8   <= day_full[4:0];
			month_s8 <= month;
			year_s8  <= year;
		end
	end

endmodule

// ===== sv/timestamp_to_calendar_date.sv =====
// timestamp_to_calendar_date: raw 32-bit telemetry timestamp to UTC calendar fields
// depends on ts2cd_pkg, ts2cd_if, ts2cd_pipe_ctrl, ts2cd_day_split, ts2cd_clock, ts2cd_civil
//
//   channel    dir  handshake      payload
//   stamp      in   valid/ready    byte_0 .. byte_3
//   calendar   out  valid/ready    day, month, year, hour, minute, second
//   wr_*       in   wr_en only     register index and 17-bit data
//
// eight register stages; an item taken in moves from stage to stage as each load enable allows,
// up to the output register, where its result can be taken
// one item per cycle sustained while calendar.ready stays high; the last stage is the output register
// a stall at the output fills empty stages first, then holds stamp.ready low
// reset clears the valid bits and sets big-endian order with zero offset

module timestamp_to_calendar_date import ts2cd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ts2cd_stamp_if.sink           stamp,
	ts2cd_cal_if.source           calendar,
	input  logic                  wr_en,
	input  cfg_reg_t              wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic                       big_endian_q;
	logic signed [OFFSET_W-1:0] utc_offset_q;
	pipe_ctl_t                  ctl;
	logic [Z_W-1:0]             z_s3;
	logic [SECS_W-1:0]          secs_s3;
	logic [4:0]                 hour_s8;
	logic [5:0]                 min_s8;
	logic [5:0]                 sec_s8;
	logic [4:0]                 day_s8;
	logic [3:0]                 month_s8;
	logic [11:0]                year_s8;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			utc_offset_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BIG_ENDIAN: big_endian_q <= wr_data[0];
				REG_UTC_OFFSET: utc_offset_q <= wr_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// stage control
	ts2cd_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stamp.valid),
		.out_ready(calendar.ready),
		.ctl      (ctl)
	);

	ts2cd_day_split u_split (
		.clk       (clk),
		.ctl       (ctl),
		.stamp     (stamp.payload),
		.big_endian(big_endian_q),
		.utc_offset(utc_offset_q),
		.z_s3      (z_s3),
		.secs_s3   (secs_s3)
	);

	ts2cd_clock u_clock (
		.clk    (clk),
		.ctl    (ctl),
		.secs_s3(secs_s3),
		.hour_s8(hour_s8),
		.min_s8 (min_s8),
		.sec_s8 (sec_s8)
	);

	ts2cd_civil u_civil (
		.clk     (clk),
		.ctl     (ctl),
		.z_s3    (z_s3),
		.day_s8  (day_s8),
		.month_s8(month_s8),
		.year_s8 (year_s8)
	);

	// channel outputs
	assign stamp.ready    = ctl.en[1];
	assign calendar.valid = ctl.vld[STAGES];

	always_comb begin
		calendar.payload.day_of_month     = day_s8;
		calendar.payload.month_number     = month_s8;
		calendar.payload.year_full        = year_s8;
		calendar.payload.hour_of_day      = hour_s8;
		calendar.payload.minute_of_hour   = min_s8;
		calendar.payload.second_of_minute = sec_s8;
	end

`ifndef SYNTH
	// input is refused only when every stage holds an item
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!stamp.ready |-> (&ctl.vld))
		else $error("input blocked with an empty stage");

	// an accepted item lands in the first stage
	a_first_stage_load: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp.valid && stamp.ready) |=> ctl.vld[1])
		else $error("accepted item lost at the first stage");

	// month, hour, minute and second stay in their ranges, and the day of the month is at least 1
	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.payload.month_number >= 4'd1
			&& calendar.payload.month_number <= 4'd12
			&& calendar.payload.day_of_month >= 5'd1
			&& calendar.payload.hour_of_day <= 5'd23
			&& calendar.payload.minute_of_hour <= 6'd59
			&& calendar.payload.second_of_minute <= 6'd59))
		else $error("calendar field out of range");
`endif

endmodule

// ===== tb/timestamp_to_calendar_date_tb.sv =====
// timestamp_to_calendar_date_tb: self-checking bench for the timestamp to calendar converter
// depends on ts2cd_pkg, ts2cd_if and the timestamp_to_calendar_date rtl
// a queue-fed driver and a monitor check every calendar item against a built-in predictor

module timestamp_to_calendar_date_tb import ts2cd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS    = 246;
	localparam int unsigned DRAIN_CYCLES   = STAGES + 4;
	localparam int unsigned REPORT_MAX     = 10;
	localparam longint      DAY_SECONDS    = 86400;
	localparam longint      EPOCH_SECONDS  = 3804 * 86400;

	// timestamp with the calendar item it should produce
	typedef struct {
		stamp_t stamp;
		cal_t   cal;
	} cal_check_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	cfg_reg_t              wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	ts2cd_stamp_if stamp_ch ();
	ts2cd_cal_if   cal_ch ();

	// register copies used by the predictor
	logic                  model_big_endian;
	logic signed [16:0]    model_offset;

	stamp_t     stamp_pending[$];
	cal_check_t cal_expected[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          sender_hold;
	bit          stamp_taken;
	int unsigned error_count;
	int unsigned stamps_sent;
	int unsigned results_checked;
	int unsigned quiet_cycles;

	logic [31:0] directed_words[$] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h8080_8080, 32'h7F7F_7F7F, 32'h0001_5180,
		32'h0001_517F, 32'hFFFE_AE80, 32'h24D6_397F, 32'h24D6_3980,
		32'h2524_01FF, 32'h2524_0200, 32'h2525_537F, 32'hA5A5_A5A5,
		32'h5A5A_5A5A, 32'hDEAD_BEEF
	};

	timestamp_to_calendar_date u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stamp    (stamp_ch),
		.calendar (cal_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint div_floor(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// join the bytes, add the epoch less the zone offset, split into civil date and time of day
	function automatic cal_t predict_calendar(input stamp_t s, input logic big_end,
			input logic signed [16:0] offset);
		logic [31:0] word;
		longint      total, days, secs;
		longint      z, era, doe, yoe, doy, mp, dd, mm, yy;
		cal_t        c;
		if (big_end) begin
			word = {s.byte_0, s.byte_1, s.byte_2, s.byte_3};
		end else begin
			word = {s.byte_3, s.byte_2, s.byte_1, s.byte_0};
		end
		total = EPOCH_SECONDS - longint'(offset) + longint'(signed'(word));
		days  = div_floor(total, DAY_SECONDS);
		secs  = total - days * DAY_SECONDS;
		// days since 1970 to year, month, day in march-based eras
		z   = days + 719468;
		era = div_floor(z, 146097);
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		dd  = doy - (153 * mp + 2) / 5 + 1;
		mm  = (mp < 10) ? mp + 3 : mp - 9;
		yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
		c.day_of_month     = dd[4:0];
		c.month_number     = mm[3:0];
		c.year_full        = yy[11:0];
		c.hour_of_day      = 5'(secs / 3600);
		c.minute_of_hour   = 6'((secs / 60) % 60);
		c.second_of_minute = 6'(secs % 60);
		return c;
	endfunction

	// lay out a 32-bit count in the byte order the block currently expects
	function automatic stamp_t stamp_from_word(input logic [31:0] w, input logic big_end);
		stamp_t s;
		if (big_end) begin
			s = w;
		end else begin
			s = {w[7:0], w[15:8], w[23:16], w[31:24]};
		end
		return s;
	endfunction

	// counts near zero and near both wrap points, plus fully random words
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		case ($urandom_range(9))
			0, 1: begin
				w = $urandom_range(400000) - 200000;
			end
			2: begin
				w = 32'h7FFF_FFFF - $urandom_range(100000);
			end
			3: begin
				w = 32'h8000_0000 + $urandom_range(100000);
			end
			default: begin
				w = $urandom();
			end
		endcase
		return w;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_MAX) begin
			$display("%s", msg);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_BIG_ENDIAN) begin
			model_big_endian = data[0];
		end else begin
			model_offset = data;
		end
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n) begin
			stamp_pending.push_back(stamp_from_word(random_word(), model_big_endian));
		end
	endtask

	// wait until every queued item is taken and every result checked
	task automatic wait_drained();
		while (stamp_pending.size() != 0 || stamp_ch.valid || cal_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// sender: present the next pending item, or idle at random
	always @(negedge clk) begin
		if (!arst_n) begin
			stamp_ch.valid <= 1'b0;
		end else if (!stamp_ch.valid || stamp_taken) begin
			if (!sender_hold && stamp_pending.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				stamp_ch.payload <= stamp_pending.pop_front();
				stamp_ch.valid   <= 1'b1;
			end else begin
				stamp_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure on the calendar channel
	always @(negedge clk) begin
		cal_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: predict on each taken timestamp, check each calendar item
	always @(posedge clk) begin
		cal_check_t want;
		bit         in_acc;
		bit         out_acc;
		in_acc  = arst_n && stamp_ch.valid && stamp_ch.ready;
		out_acc = arst_n && cal_ch.valid && cal_ch.ready;
		stamp_taken = in_acc;
		if (in_acc) begin
			want.stamp = stamp_ch.payload;
			want.cal   = predict_calendar(stamp_ch.payload, model_big_endian, model_offset);
			cal_expected.push_back(want);
			stamps_sent++;
		end
		if (out_acc) begin
			if (cal_expected.size() == 0) begin
				report_error($sformatf("unexpected calendar item %0d-%0d-%0d %0d:%0d:%0d",
					cal_ch.payload.year_full, cal_ch.payload.month_number,
					cal_ch.payload.day_of_month, cal_ch.payload.hour_of_day,
					cal_ch.payload.minute_of_hour, cal_ch.payload.second_of_minute));
			end else begin
				want = cal_expected.pop_front();
				results_checked++;
				if (cal_ch.payload !== want.cal) begin
					report_error($sformatf({"mismatch for stamp %h: expected %0d-%0d-%0d",
						" %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d"}, want.stamp,
						want.cal.year_full, want.cal.month_number, want.cal.day_of_month,
						want.cal.hour_of_day, want.cal.minute_of_hour,
						want.cal.second_of_minute,
						cal_ch.payload.year_full, cal_ch.payload.month_number,
						cal_ch.payload.day_of_month, cal_ch.payload.hour_of_day,
						cal_ch.payload.minute_of_hour, cal_ch.payload.second_of_minute));
				end
			end
		end
		// watchdog on cycles with no handshake at all
		if (!arst_n || in_acc || out_acc) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = REG_BIG_ENDIAN;
		wr_data          = '0;
		stamp_ch.valid   = 1'b0;
		stamp_ch.payload = '0;
		cal_ch.ready     = 1'b0;
		model_big_endian = 1'b1;
		model_offset     = '0;
		send_idle_pct    = 33;
		recv_idle_pct    = 48;
		sender_hold      = 1'b0;
		stamp_taken      = 1'b0;
		error_count      = 0;
		stamps_sent      = 0;
		results_checked  = 0;
		quiet_cycles     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: wrap points, day and leap-day edges, byte patterns
		foreach (directed_words[i]) begin
			stamp_pending.push_back(stamp_from_word(directed_words[i], 1'b1));
		end
		wait_drained();

		// reversed order with upper data bits set, westmost nominal offset
		write_reg(REG_BIG_ENDIAN, 17'h1FFFE);
		write_reg(REG_UTC_OFFSET, -17'sd50400);
		stamp_pending.push_back(stamp_from_word(32'h0102_0304, model_big_endian));
		stamp_pending.push_back(stamp_from_word(32'h8000_0000, model_big_endian));
		stamp_pending.push_back(stamp_from_word(32'h7FFF_FFFF, model_big_endian));
		queue_random(PHASE_ITEMS);
		wait_drained();

		// swap idle rates; eastmost nominal offset; sender pauses mid-stream
		send_idle_pct = 48;
		recv_idle_pct = 33;
		write_reg(REG_BIG_ENDIAN, 17'h15555);
		write_reg(REG_UTC_OFFSET, 17'sd50400);
		queue_random(PHASE_ITEMS);
		while (stamp_pending.size() > PHASE_ITEMS / 2) begin
			@(posedge clk);
		end
		sender_hold = 1'b1;
		while (stamp_ch.valid || cal_expected.size() != 0) begin
			@(posedge clk);
		end
		sender_hold = 1'b0;
		wait_drained();

		// offsets beyond the nominal range, most negative register value
		write_reg(REG_BIG_ENDIAN, 17'h00000);
		write_reg(REG_UTC_OFFSET, 17'h10000);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// no idling from here on; most positive register value
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_BIG_ENDIAN, 17'h00001);
		write_reg(REG_UTC_OFFSET, 17'h0FFFF);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// random register values
		write_reg(REG_BIG_ENDIAN, CFG_DATA_W'($urandom()));
		write_reg(REG_UTC_OFFSET, CFG_DATA_W'($urandom()));
		queue_random(PHASE_ITEMS);
		wait_drained();

		$display("sent %0d timestamps, checked %0d calendar items, %0d errors",
			stamps_sent, results_checked, error_count);
		$display("covered both byte orders, offset extremes and both idle profiles");
		if (error_count == 0 && cal_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
